// ===== hw/rtl/ncdr_pkg.sv =====
// Shared types, constants and helpers for the nearest color dither reduction block.
// No dependencies.
package ncdr_pkg;

  localparam int TABLE_DEPTH   = 256;
  localparam int PALETTE_DEPTH = 256;
  localparam int TBL_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  // compare width for slot, entry number and entry count
  localparam int CMP_W = (TBL_AW + 1 > 9) ? TBL_AW + 1 : 9;
  localparam int ERR_W = 9;
  localparam logic [ERR_W-1:0] NO_MATCH_ERR = 9'd256;

  typedef enum logic [1:0] {
    CMD_LOAD_ENTRY   = 2'd0,
    CMD_LOAD_PALETTE = 2'd1,
    CMD_PIXEL        = 2'd2,
    CMD_NONE         = 2'd3
  } cmd_t;

  typedef struct packed {
    logic              valid;
    cmd_t              cmd;
    logic [7:0]        slot;
    logic [31:0]       color;
    logic [7:0]        idx_first;
    logic [7:0]        idx_second;
    logic              x_odd;
    logic              y_odd;
    logic [ERR_W-1:0]  best_err;
    logic [TBL_AW-1:0] best_slot;
    logic [7:0]        best_first;
    logic [7:0]        best_second;
  } item_t;

  function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
    abs_diff8 = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [7:0] cheb_rgb(input logic [23:0] p, input logic [23:0] q);
    logic [7:0] dr;
    logic [7:0] dg;
    logic [7:0] db;
    logic [7:0] m;
    dr = abs_diff8(p[23:16], q[23:16]);
    dg = abs_diff8(p[15:8], q[15:8]);
    db = abs_diff8(p[7:0], q[7:0]);
    m = dr;
    if (dg > m) m = dg;
    if (db > m) m = db;
    cheb_rgb = m;
  endfunction

endpackage

// ===== hw/rtl/ncdr_cell.sv =====
// One cell of the search chain: holds one dither entry and compares it to a passing pixel.
// Depends on ncdr_pkg.
module ncdr_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic [ncdr_pkg::TBL_AW-1:0] cell_idx,
  input  logic [ncdr_pkg::CMP_W-1:0]  count,
  input  ncdr_pkg::item_t           item_in,
  output ncdr_pkg::item_t           item_out
);

  logic [23:0]     blend_r;
  logic [7:0]      first_r;
  logic [7:0]      second_r;
  ncdr_pkg::item_t item_r;
  ncdr_pkg::item_t item_nxt;
  logic [7:0]      err;
  logic            hit_load;

  assign hit_load = item_in.valid && (item_in.cmd == ncdr_pkg::CMD_LOAD_ENTRY)
                    && (ncdr_pkg::CMP_W'(item_in.slot) == ncdr_pkg::CMP_W'(cell_idx));
  assign err = ncdr_pkg::cheb_rgb(item_in.color[23:0], blend_r);

  always_comb begin
    item_nxt = item_in;
    if (item_in.valid && (item_in.cmd == ncdr_pkg::CMD_PIXEL)
        && (ncdr_pkg::CMP_W'(cell_idx) < count)
        && ({1'b0, err} < item_in.best_err)) begin
      item_nxt.best_err    = {1'b0, err};
      item_nxt.best_slot   = cell_idx;
      item_nxt.best_first  = first_r;
      item_nxt.best_second = second_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && hit_load) begin
      blend_r  <= item_in.color[23:0];
      first_r  <= item_in.idx_first;
      second_r <= item_in.idx_second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r <= '0;
    end else if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign item_out = item_r;

endmodule

// ===== hw/rtl/nearest_color_dither_reduction_top.sv =====
// Top level of the nearest color dither reduction block: search chain, palette, output.
// Depends on ncdr_pkg and ncdr_cell.
//
// Usage: items enter on the in_ channel (valid/stall). Load-entry items write one
// dither entry, load-palette items write one palette color, pixel items give one
// result on the out_ channel; other commands give nothing. Each item walks a chain
// of TABLE_DEPTH cells, one dither entry per cell, then the output register, which
// also reads the palette. One item enters every cycle when out_stall is low. Loads
// take effect in item order, because they walk the same chain as pixels.
// entry_count is written at byte address 0 of the APB port; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Reset clears the chain valid bits, the output valid and sets entry_count to 1;
// dither entries and palette colors are undefined until loaded.
// While a result is held and out_stall is high the whole chain freezes and
// in_stall is raised; nothing is lost or repeated.
module nearest_color_dither_reduction_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_slot,
  input  logic [31:0] in_color,
  input  logic [7:0]  in_index_first,
  input  logic [7:0]  in_index_second,
  input  logic        in_x_odd,
  input  logic        in_y_odd,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_palette_index,
  output logic [31:0] out_out_color,
  output logic [7:0]  out_match_slot,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [8:0]                 count_r;
  logic [ncdr_pkg::CMP_W-1:0] count_eff;
  logic                       adv;
  ncdr_pkg::item_t            head;
  ncdr_pkg::item_t            chain [0:ncdr_pkg::TABLE_DEPTH];
  ncdr_pkg::item_t            last;
  logic [31:0]                pal_mem [0:ncdr_pkg::PALETTE_DEPTH-1];
  logic [7:0]                 pal_idx;
  logic                       out_valid_r;
  logic [7:0]                 palette_index_r;
  logic [31:0]                out_color_r;
  logic [7:0]                 match_slot_r;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {23'd0, count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 9'd1;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      count_r <= pwdata[8:0];
    end
  end

  always_comb begin
    if (count_r == 9'd0) begin
      count_eff = ncdr_pkg::CMP_W'(1);
    end else if (ncdr_pkg::CMP_W'(count_r) > ncdr_pkg::CMP_W'(ncdr_pkg::TABLE_DEPTH)) begin
      count_eff = ncdr_pkg::CMP_W'(ncdr_pkg::TABLE_DEPTH);
    end else begin
      count_eff = ncdr_pkg::CMP_W'(count_r);
    end
  end

  assign adv = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_comb begin
    head             = '0;
    head.valid       = in_valid;
    head.cmd         = ncdr_pkg::cmd_t'(in_command);
    head.slot        = in_slot;
    head.color       = in_color;
    head.idx_first   = in_index_first;
    head.idx_second  = in_index_second;
    head.x_odd       = in_x_odd;
    head.y_odd       = in_y_odd;
    head.best_err    = ncdr_pkg::NO_MATCH_ERR;
  end

  assign chain[0] = head;

  for (genvar k = 0; k < ncdr_pkg::TABLE_DEPTH; k++) begin : g_cell
    ncdr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_idx (ncdr_pkg::TBL_AW'(k)),
      .count    (count_eff),
      .item_in  (chain[k]),
      .item_out (chain[k+1])
    );
  end

  assign last = chain[ncdr_pkg::TABLE_DEPTH];
  // first index when column and row parity differ
  assign pal_idx = (last.x_odd ^ last.y_odd) ? last.best_first : last.best_second;

  always_ff @(posedge clk) begin
    if (adv && last.valid && (last.cmd == ncdr_pkg::CMD_LOAD_PALETTE)
        && (9'(last.slot) < 9'(ncdr_pkg::PALETTE_DEPTH))) begin
      pal_mem[last.slot[ncdr_pkg::PAL_AW-1:0]] <= last.color;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      palette_index_r <= pal_idx;
      match_slot_r    <= 8'(last.best_slot);
      if (9'(pal_idx) < 9'(ncdr_pkg::PALETTE_DEPTH)) begin
        out_color_r <= pal_mem[pal_idx[ncdr_pkg::PAL_AW-1:0]];
      end else begin
        out_color_r <= 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= last.valid && (last.cmd == ncdr_pkg::CMD_PIXEL);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_palette_index = palette_index_r;
  assign out_out_color     = out_color_r;
  assign out_match_slot    = match_slot_r;

`ifndef SYNTHESIS
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid_r && out_stall))
    else $error("in_stall disagrees with output hold");

  a_result_from_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !(last.valid && last.cmd == ncdr_pkg::CMD_PIXEL)) |=> !out_valid_r)
    else $error("result without pixel item");

  a_match_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last.valid && last.cmd == ncdr_pkg::CMD_PIXEL)
      |-> (ncdr_pkg::CMP_W'(last.best_slot) < count_eff))
    else $error("match beyond entry count");
`endif

endmodule

// ===== bench/nearest_color_dither_reduction_top_test.sv =====
// Testbench for nearest_color_dither_reduction_top: loads, pixel lookups, entry_count.
// Depends on ncdr_pkg and the RTL of the block; predicts each pixel result itself.
`timescale 1ns / 100ps

module nearest_color_dither_reduction_top_test;

  typedef struct packed {
    logic [7:0]  palette_index;
    logic [31:0] color;
    logic [7:0]  match_slot;
  } pixel_result_t;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  ncdr_pkg::cmd_t  in_command;
  logic [7:0]      in_slot;
  logic [31:0]     in_color;
  logic [7:0]      in_index_first;
  logic [7:0]      in_index_second;
  logic            in_x_odd;
  logic            in_y_odd;
  logic            out_valid;
  logic            out_stall;
  logic [7:0]      out_palette_index;
  logic [31:0]     out_out_color;
  logic [7:0]      out_match_slot;
  logic            psel;
  logic            penable;
  logic            pwrite;
  logic [2:0]      paddr;
  logic [31:0]     pwdata;
  logic [31:0]     prdata;
  logic            pready;

  // predictor copy of the block's state
  logic [23:0] blend_mirror [ncdr_pkg::TABLE_DEPTH];
  logic [7:0]  first_mirror [ncdr_pkg::TABLE_DEPTH];
  logic [7:0]  second_mirror [ncdr_pkg::TABLE_DEPTH];
  logic [31:0] palette_mirror [ncdr_pkg::PALETTE_DEPTH];
  logic [8:0]  entry_count_mirror;

  pixel_result_t expected_pixels[$];
  int          fail_count;
  bit          quiet_phase;

  localparam int DRAIN_CYCLES = ncdr_pkg::TABLE_DEPTH + 40;

  nearest_color_dither_reduction_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] abs8(logic [7:0] a, logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic pixel_result_t predict_pixel(logic [31:0] color, logic x_odd,
                                                  logic y_odd);
    pixel_result_t res;
    int          count;
    int          best;
    logic [8:0]  best_dist;
    logic [7:0]  ch_err;
    logic [7:0]  idx;
    count = entry_count_mirror;
    if (count == 0) count = 1;
    if (count > ncdr_pkg::TABLE_DEPTH) count = ncdr_pkg::TABLE_DEPTH;
    best = 0;
    best_dist = 9'd256;
    for (int i = 0; i < count; i++) begin
      ch_err = abs8(color[23:16], blend_mirror[i][23:16]);
      if (abs8(color[15:8], blend_mirror[i][15:8]) > ch_err)
        ch_err = abs8(color[15:8], blend_mirror[i][15:8]);
      if (abs8(color[7:0], blend_mirror[i][7:0]) > ch_err)
        ch_err = abs8(color[7:0], blend_mirror[i][7:0]);
      if ({1'b0, ch_err} < best_dist) begin
        best_dist = {1'b0, ch_err};
        best = i;
      end
    end
    // first index where column and row parity differ
    idx = (x_odd != y_odd) ? first_mirror[best] : second_mirror[best];
    res.palette_index = idx;
    res.color = palette_mirror[idx];
    res.match_slot = best[7:0];
    return res;
  endfunction

  task automatic send_item(ncdr_pkg::cmd_t cmd, logic [7:0] slot, logic [31:0] color,
                           logic [7:0] idx_a, logic [7:0] idx_b, logic x_odd,
                           logic y_odd);
    int gap;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_slot <= slot;
    in_color <= color;
    in_index_first <= idx_a;
    in_index_second <= idx_b;
    in_x_odd <= x_odd;
    in_y_odd <= y_odd;
    do @(posedge clk); while (in_stall);
    case (cmd)
      ncdr_pkg::CMD_LOAD_ENTRY: begin
        blend_mirror[slot] = color[23:0];
        first_mirror[slot] = idx_a;
        second_mirror[slot] = idx_b;
      end
      ncdr_pkg::CMD_LOAD_PALETTE: palette_mirror[slot] = color;
      ncdr_pkg::CMD_PIXEL: expected_pixels.push_back(predict_pixel(color, x_odd, y_odd));
      default: ;
    endcase
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_pixel(logic [31:0] color, logic x_odd, logic y_odd);
    send_item(ncdr_pkg::CMD_PIXEL, 8'($urandom), color, 8'($urandom), 8'($urandom),
              x_odd, y_odd);
  endtask

  // waits for all results, lets trailing loads drain, then writes entry_count
  task automatic set_entry_count(logic [8:0] value);
    in_valid <= 1'b0;
    wait (expected_pixels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= {23'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    entry_count_mirror = value;
  endtask

  // result checker; out_stall idles at random
  always @(posedge clk) begin
    pixel_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result idx %0d color %h slot %0d", $time,
                 out_palette_index, out_out_color, out_match_slot);
        fail_count++;
      end else begin
        exp_res = expected_pixels.pop_front();
        if (out_palette_index !== exp_res.palette_index) begin
          $display("%0t: palette_index expected %0d actual %0d", $time,
                   exp_res.palette_index, out_palette_index);
          fail_count++;
        end
        if (out_out_color !== exp_res.color) begin
          $display("%0t: out_color expected %h actual %h", $time, exp_res.color,
                   out_out_color);
          fail_count++;
        end
        if (out_match_slot !== exp_res.match_slot) begin
          $display("%0t: match_slot expected %0d actual %0d", $time,
                   exp_res.match_slot, out_match_slot);
          fail_count++;
        end
      end
    end
    out_stall <= (pick_gap() > 2);
  end

  // every store entry is written once so no read hits an unwritten entry
  task automatic test_fill_stores();
    for (int i = 0; i < ncdr_pkg::TABLE_DEPTH; i++)
      send_item(ncdr_pkg::CMD_LOAD_ENTRY, 8'(i), $urandom, 8'($urandom), 8'($urandom),
                1'b0, 1'b0);
    for (int i = 0; i < ncdr_pkg::PALETTE_DEPTH; i++)
      send_item(ncdr_pkg::CMD_LOAD_PALETTE, 8'(i), $urandom, 8'd0, 8'd0, 1'b0, 1'b0);
  endtask

  task automatic test_directed();
    // reset entry_count of one: entry 0 always matches, all parities
    for (int p = 0; p < 4; p++) send_pixel($urandom, p[0], p[1]);
    set_entry_count(9'd256);
    send_item(ncdr_pkg::CMD_LOAD_ENTRY, 8'd0, 32'hFF000000, 8'd0, 8'd255, 1'b0, 1'b0);
    send_item(ncdr_pkg::CMD_LOAD_ENTRY, 8'd255, 32'h00FFFFFF, 8'd255, 8'd0, 1'b0, 1'b0);
    send_item(ncdr_pkg::CMD_LOAD_ENTRY, 8'd7, 32'h12345678, 8'd3, 8'd4, 1'b0, 1'b0);
    send_item(ncdr_pkg::CMD_LOAD_ENTRY, 8'd9, 32'hAB345678, 8'd5, 8'd6, 1'b0, 1'b0);
    send_item(ncdr_pkg::CMD_LOAD_PALETTE, 8'd255, 32'hFFFFFFFF, 8'd0, 8'd0, 1'b0, 1'b0);
    send_item(ncdr_pkg::CMD_LOAD_PALETTE, 8'd0, 32'h00000000, 8'd0, 8'd0, 1'b0, 1'b0);
    send_pixel(32'h00000000, 1'b0, 1'b0);
    send_pixel(32'hFFFFFFFF, 1'b1, 1'b0);
    send_pixel(32'h00FFFFFF, 1'b0, 1'b1);
    // tie between slots 7 and 9: lower slot wins
    send_pixel(32'h00345678, 1'b1, 1'b1);
    send_pixel(32'h12345678, 1'b1, 1'b0);
    // ignored command and a lone pixel
    send_item(ncdr_pkg::CMD_NONE, 8'($urandom), $urandom, 8'($urandom), 8'($urandom),
              1'b1, 1'b1);
    send_pixel(32'h80808080, 1'b0, 1'b1);
    // zero count acts as one, oversized count saturates
    set_entry_count(9'd0);
    send_pixel($urandom, 1'b1, 1'b0);
    send_pixel($urandom, 1'b0, 1'b0);
    set_entry_count(9'd511);
    send_pixel($urandom, 1'b1, 1'b0);
    send_pixel(32'h00FFFFFF, 1'b0, 1'b0);
  endtask

  task automatic test_random(int items);
    int r;
    logic [7:0] s;
    for (int n = 0; n < items; n++) begin
      r = $urandom_range(0, 99);
      s = 8'($urandom);
      if (r < 12) begin
        send_item(ncdr_pkg::CMD_LOAD_ENTRY, s, $urandom, 8'($urandom), 8'($urandom),
                  1'($urandom), 1'($urandom));
      end else if (r < 20) begin
        send_item(ncdr_pkg::CMD_LOAD_PALETTE, s, $urandom, 8'($urandom), 8'($urandom),
                  1'($urandom), 1'($urandom));
      end else if (r < 23) begin
        send_item(ncdr_pkg::CMD_NONE, s, $urandom, 8'($urandom), 8'($urandom),
                  1'($urandom), 1'($urandom));
      end else if (r < 55) begin
        // near a stored blend color so the search has close contenders
        send_pixel({8'($urandom), blend_mirror[s] ^ 24'($urandom_range(0, 7) * 'h10101)},
                   1'($urandom), 1'($urandom));
      end else begin
        send_pixel($urandom, 1'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    logic [8:0] counts [8] = '{9'd1, 9'd256, 9'd2, 9'd17, 9'd128, 9'd255, 9'd64, 9'd3};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = ncdr_pkg::CMD_NONE;
    in_slot = '0;
    in_color = '0;
    in_index_first = '0;
    in_index_second = '0;
    in_x_odd = 1'b0;
    in_y_odd = 1'b0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_count = 0;
    quiet_phase = 1'b0;
    entry_count_mirror = 9'd1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_stores();
    test_directed();
    for (int ph = 0; ph < 8; ph++) begin
      set_entry_count(counts[ph]);
      quiet_phase = (ph == 3);
      test_random(130);
    end
    quiet_phase = 1'b0;
    in_valid <= 1'b0;
    wait (expected_pixels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
